// ===== rtl/vdd_pkg.sv =====
// Shared types and constants for the seam-aware vertex dedup block.
// Used by the front classifier, the corner queue, the back end and the top level.
package vdd_pkg;

  localparam int VI_W      = 10;
  localparam int TEX_W     = 12;
  localparam int NTEX_S_W  = 13;
  localparam int OUT_IDX_W = 11;
  localparam int SKIN_W    = 13;
  localparam int VCOUNT_W  = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIN_WIDTH   = 1'b0,
    CFG_VERTEX_COUNT = 1'b1
  } cfg_reg_t;

  // One classified corner, as it travels from the front to the back end.
  typedef struct packed {
    logic                first;
    logic                bad;
    logic                back;
    logic [VI_W-1:0]     vert_index;
    logic [NTEX_S_W-1:0] adj_s;
    logic [TEX_W-1:0]    tex_t;
  } corner_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] out_index;
    logic                 is_new_vertex;
    logic [VI_W-1:0]      new_source_vertex;
    logic [NTEX_S_W-1:0]  new_tex_s;
    logic [TEX_W-1:0]     new_tex_t;
    logic                 bad_vertex;
  } result_t;

endpackage

// ===== rtl/seam_aware_vertex_dedup.sv =====
// Top level of the seam-aware vertex dedup block: stream ports and config registers.
// Depends on vdd_pkg, vdd_front, vdd_fifo and vdd_back.
//
// The block turns a stream of triangle corners into deduplicated output vertex
// indices, one result transfer per corner, in order. Each source vertex owns
// two slots, one for front use and one for a back-facing corner on the skin
// seam; the first use of a slot assigns the next output number and reports the
// new vertex with its seam-adjusted s coordinate. A corner whose vertex number
// is not below vertex_count (or MAX_SOURCE_VERTS) returns only bad_vertex.
// The front part classifies corners as they arrive and places them in a
// two-entry queue, so the input keeps flowing while the back end works. The
// back end takes each corner in turn through four steps: a forward remap read,
// a dependent reverse remap read, the compare and update, and the output
// register load, which waits until the last result is taken; a bad corner
// skips to the load. A corner flagged first_of_model restarts the model by
// zeroing the vertex counter; the reverse-map check makes every old entry
// stale at once, so there is no clearing pass after reset or between models.
// Configuration writes take effect at the edge where cfg_we is high and must
// be made while no corner is in flight.
module seam_aware_vertex_dedup #(
  parameter int MAX_SOURCE_VERTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata from bit 0: vert_index[9:0], faces_front, on_seam, tex_s[11:0],
  // tex_t[11:0], zero fill to 40 bits.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,
  // s_tuser from bit 0: first_of_model.
  input  logic [0:0]                     s_tuser,
  // m_tdata from bit 0: out_index[10:0], new_source_vertex[9:0], new_tex_s[12:0],
  // new_tex_t[11:0], zero fill to 48 bits.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [47:0]                    m_tdata,
  // m_tuser from bit 0: is_new_vertex, bad_vertex.
  output logic [1:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [vdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vdd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vdd_pkg::*;

  logic [SKIN_W-1:0]   skin_width;
  logic [VCOUNT_W-1:0] vertex_count;
  corner_t             corner;
  corner_t             head;
  logic                full;
  logic                empty;
  logic                pop;
  result_t             res;

  // Configuration registers; only the two listed indexes exist.
  always_ff @(posedge clk) begin
    if (rst) begin
      skin_width   <= SKIN_W'(320);
      vertex_count <= VCOUNT_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKIN_WIDTH:   skin_width   <= cfg_data[SKIN_W-1:0];
        CFG_VERTEX_COUNT: vertex_count <= cfg_data[VCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  vdd_front #(.MAX_SOURCE_VERTS(MAX_SOURCE_VERTS)) u_front (
    .first_of_model (s_tuser[0]),
    .vert_index     (s_tdata[9:0]),
    .faces_front    (s_tdata[10]),
    .on_seam        (s_tdata[11]),
    .tex_s          (s_tdata[23:12]),
    .tex_t          (s_tdata[35:24]),
    .skin_width     (skin_width),
    .vertex_count   (vertex_count),
    .corner         (corner)
  );

  // A corner transfer is taken whenever the queue has room.
  assign s_tready = !full;

  vdd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (corner),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  vdd_back #(.MAX_SOURCE_VERTS(MAX_SOURCE_VERTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .res_out   (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = {2'b00, res.new_tex_t, res.new_tex_s, res.new_source_vertex,
                    res.out_index};
  assign m_tuser = {res.bad_vertex, res.is_new_vertex};

endmodule

// ===== rtl/vdd_front.sv =====
// Front classifier: range check, seam slot choice and seam s adjustment.
// Depends on vdd_pkg for the corner record.
module vdd_front #(
  parameter int MAX_SOURCE_VERTS = 1024
) (
  input  logic                          first_of_model,
  input  logic [vdd_pkg::VI_W-1:0]      vert_index,
  input  logic                          faces_front,
  input  logic                          on_seam,
  input  logic [vdd_pkg::TEX_W-1:0]     tex_s,
  input  logic [vdd_pkg::TEX_W-1:0]     tex_t,
  input  logic [vdd_pkg::SKIN_W-1:0]    skin_width,
  input  logic [vdd_pkg::VCOUNT_W-1:0]  vertex_count,
  output vdd_pkg::corner_t              corner
);
  import vdd_pkg::*;

  logic back;
  logic bad;
  logic [NTEX_S_W-1:0] half_skin;

  assign back      = !faces_front && on_seam;
  assign bad       = ({1'b0, vert_index} >= vertex_count) ||
                     (32'(vert_index) >= MAX_SOURCE_VERTS);
  assign half_skin = NTEX_S_W'(skin_width >> 1);

  always_comb begin
    corner.first      = first_of_model;
    corner.bad        = bad;
    corner.back       = back;
    corner.vert_index = vert_index;
    corner.tex_t      = tex_t;
    if (back) begin
      corner.adj_s = NTEX_S_W'(tex_s) + half_skin;
    end else begin
      corner.adj_s = NTEX_S_W'(tex_s);
    end
  end

endmodule

// ===== rtl/vdd_fifo.sv =====
// Two-entry queue of classified corners between the front and the back end.
// Depends on vdd_pkg for the corner record.
module vdd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vdd_pkg::corner_t push_data,
  output logic             full,
  input  logic             pop,
  output vdd_pkg::corner_t head,
  output logic             empty
);
  import vdd_pkg::*;

  corner_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== rtl/vdd_back.sv =====
// Back end: slot lookup in the remap memories, vertex assignment and result register.
// Depends on vdd_pkg for the corner and result records.
module vdd_back #(
  parameter int MAX_SOURCE_VERTS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  vdd_pkg::corner_t head,
  input  logic             empty,
  output logic             pop,
  output vdd_pkg::result_t res_out,
  output logic             res_valid,
  input  logic             res_ready
);
  import vdd_pkg::*;

  localparam int SLOTS = 2 * MAX_SOURCE_VERTS;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = SW + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_FWD, ST_REV, ST_OUT} state_t;

  // The forward map holds a candidate output number per slot; the reverse
  // map holds the slot that owns each output number. A slot counts as assigned only
  // when both agree below the current count, so no clearing pass is needed.
  logic [CW-1:0] fwd_mem [SLOTS];
  logic [SW-1:0] rev_mem [SLOTS];

  state_t        state;
  corner_t       cur;
  logic [SW-1:0] slot;
  logic [CW-1:0] fwd_q;
  logic [SW-1:0] rev_q;
  logic [CW-1:0] count;
  result_t       res;
  logic          hit;
  logic          miss_write;
  logic [SW-1:0] head_slot;

  assign head_slot  = SW'({head.vert_index, head.back});
  assign pop        = (state == ST_IDLE) && !empty;
  assign miss_write = (state == ST_REV) && !hit;

  always_comb begin
    hit = 1'b0;
    if ((fwd_q < count) && (rev_q == slot)) begin
      hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fwd_q <= fwd_mem[head_slot];
    end
    if (state == ST_FWD) begin
      rev_q <= rev_mem[fwd_q[SW-1:0]];
    end
    if (miss_write) begin
      fwd_mem[slot]           <= count;
      rev_mem[count[SW-1:0]]  <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // In the output state the valid flag is handled by the load below.
      if (res_valid && res_ready && (state != ST_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            cur  <= head;
            slot <= head_slot;
            if (head.first) begin
              count <= '0;
            end
            if (head.bad) begin
              res   <= '{bad_vertex: 1'b1, default: '0};
              state <= ST_OUT;
            end else begin
              state <= ST_FWD;
            end
          end
        end
        ST_FWD: begin
          state <= ST_REV;
        end
        ST_REV: begin
          if (hit) begin
            res <= '{out_index: OUT_IDX_W'(fwd_q), default: '0};
          end else begin
            res   <= '{out_index: OUT_IDX_W'(count), is_new_vertex: 1'b1,
                       new_source_vertex: cur.vert_index, new_tex_s: cur.adj_s,
                       new_tex_t: cur.tex_t, bad_vertex: 1'b0};
            count <= count + CW'(1);
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_valid || res_ready) begin
            res_out   <= res;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("vertex counter ran past the slot count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    miss_write |=> (count == $past(count) + CW'(1)))
    else $error("new vertex did not advance the counter");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_out.bad_vertex) |-> (!res_out.is_new_vertex && res_out.out_index == '0))
    else $error("rejected corner produced a vertex");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_FWD || state == ST_OUT))
    else $error("corner taken outside the idle state");

endmodule
